### design/ttor_pkg.sv
// ----------------------------------------------------------------------------
// ttor_pkg
// Shared types and codes for the tagged trace table with oldest replacement.
// ----------------------------------------------------------------------------
package ttor_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_STORE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Operation of the shared compare unit.
  typedef enum logic [1:0] {
    CMP_EQ = 2'b01,
    CMP_LT = 2'b10
  } cmp_op_t;

  // One stored trace record.
  typedef struct packed {
    logic [31:0]        tag;
    logic [7:0]         hops;
    logic signed [7:0]  snr_out;
    logic signed [7:0]  snr_in;
    logic [31:0]        time_ms;
    logic [31:0]        order;
  } rec_t;

  // One result before it moves to the output register.
  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [3:0]         slot;
    logic [7:0]         hops;
    logic signed [7:0]  snr_out;
    logic signed [7:0]  snr_in;
    logic [31:0]        time_ms;
    logic [31:0]        order;
  } res_t;

endpackage

### design/ttor_req_if.sv
// ----------------------------------------------------------------------------
// ttor_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface ttor_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [31:0]        tag;
  logic [7:0]         hop_num;
  logic signed [7:0]  snr_outbound;
  logic signed [7:0]  snr_inbound;
  logic [31:0]        now_ms;

  modport source (
    output valid, req_type, tag, hop_num, snr_outbound, snr_inbound, now_ms,
    input  ready
  );
  modport sink (
    input  valid, req_type, tag, hop_num, snr_outbound, snr_inbound, now_ms,
    output ready
  );
endinterface

### design/ttor_rsp_if.sv
// ----------------------------------------------------------------------------
// ttor_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface ttor_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               evicted;
  logic [3:0]         slot;
  logic [7:0]         out_hop_num;
  logic signed [7:0]  out_snr_outbound;
  logic signed [7:0]  out_snr_inbound;
  logic [31:0]        out_time_ms;
  logic [31:0]        out_order;

  modport source (
    output valid, hit, evicted, slot, out_hop_num, out_snr_outbound,
           out_snr_inbound, out_time_ms, out_order,
    input  ready
  );
  modport sink (
    input  valid, hit, evicted, slot, out_hop_num, out_snr_outbound,
           out_snr_inbound, out_time_ms, out_order,
    output ready
  );
endinterface

### design/ttor_cmp.sv
// ----------------------------------------------------------------------------
// ttor_cmp
// Shared 32-bit compare unit: tag equality or unsigned less-than on order.
// ----------------------------------------------------------------------------
module ttor_cmp (
  input  ttor_pkg::cmp_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              flag
);
  import ttor_pkg::*;

  always_comb begin
    case (op)
      CMP_EQ:  flag = (a == b);
      CMP_LT:  flag = (a < b);
      default: flag = 1'b0;
    endcase
  end
endmodule

### design/ttor_table.sv
// ----------------------------------------------------------------------------
// ttor_table
// Record memory with one write and one registered read port, plus a valid
// flag per entry that reset clears.
// ----------------------------------------------------------------------------
module ttor_table #(
  parameter int ENTRIES = 16,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [AW-1:0]   rd_addr,
  output ttor_pkg::rec_t  rd_rec,
  output logic            rd_valid,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  ttor_pkg::rec_t  wr_rec
);
  import ttor_pkg::*;

  rec_t                mem [ENTRIES];
  logic [ENTRIES-1:0]  valid;

  always_ff @(posedge clk) begin
    rd_rec <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end
endmodule

### design/tagged_table_oldest_replace_core.sv
// ----------------------------------------------------------------------------
// tagged_table_oldest_replace_core
// Fully associative trace record table keyed by a 32-bit tag, with
// oldest-entry replacement when the table is full.
// ----------------------------------------------------------------------------
// A request takes one transfer on req and gives exactly one transfer on rsp.
// The block handles one request at a time: it scans the record memory one
// entry per cycle through a single registered read port and a single compare
// unit. A lookup ends after that scan; a store writes the slot holding its
// tag or else the first free slot, and a store into a full table takes a
// second scan for the slot with the smallest sequence number. req.ready
// returns in the cycle after the result is loaded into the output register,
// where the result waits, so the next request can be accepted while a
// finished result is still held.
// The table starts empty after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tagged_table_oldest_replace_core #(
  parameter int ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst,
  ttor_req_if.sink   req,
  ttor_rsp_if.source rsp
);
  import ttor_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_AGE   = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t         state;

  // Latched request.
  logic           req_type_q;
  logic [31:0]    tag_q;
  logic [7:0]     hops_q;
  logic [7:0]     snr_out_q;
  logic [7:0]     snr_in_q;
  logic [31:0]    time_q;

  // Scan control: cnt is the address being issued, rd_idx the address whose
  // data is on the read port this cycle (valid when pend is high).
  logic [AW-1:0]  cnt;
  logic           issue_on;
  logic           pend;
  logic [AW-1:0]  rd_idx;

  // Search results.
  logic           match_found;
  logic [AW-1:0]  match_idx;
  rec_t           match_rec;
  logic           free_found;
  logic [AW-1:0]  free_idx;
  logic [31:0]    min_order;
  logic [AW-1:0]  min_idx;
  logic [AW-1:0]  tgt_idx;

  logic [31:0]    order_counter;
  res_t           res;
  res_t           out_res;
  logic           out_valid;

  // Memory and compare unit hookup.
  rec_t           rd_rec;
  logic           rd_valid;
  logic           wr_en;
  rec_t           wr_rec;
  cmp_op_t        cmp_op;
  logic [31:0]    cmp_a;
  logic [31:0]    cmp_b;
  logic           cmp_flag;

  // Search results including the entry on the read port this cycle.
  logic           m_found;
  logic [AW-1:0]  m_idx;
  rec_t           m_rec;
  logic           f_found;
  logic [AW-1:0]  f_idx;
  logic           take_min;

  ttor_table #(.ENTRIES(ENTRIES), .AW(AW)) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (cnt),
    .rd_rec   (rd_rec),
    .rd_valid (rd_valid),
    .wr_en    (wr_en),
    .wr_addr  (tgt_idx),
    .wr_rec   (wr_rec)
  );

  ttor_cmp u_cmp (
    .op   (cmp_op),
    .a    (cmp_a),
    .b    (cmp_b),
    .flag (cmp_flag)
  );

  // The first pass compares tags; the aging pass compares sequence numbers.
  always_comb begin
    if (state == ST_AGE) begin
      cmp_op = CMP_LT;
      cmp_a  = rd_rec.order;
      cmp_b  = min_order;
    end else begin
      cmp_op = CMP_EQ;
      cmp_a  = rd_rec.tag;
      cmp_b  = tag_q;
    end
  end

  always_comb begin
    m_found  = match_found | (pend & rd_valid & cmp_flag);
    m_idx    = match_found ? match_idx : rd_idx;
    m_rec    = match_found ? match_rec : rd_rec;
    f_found  = free_found | (pend & ~rd_valid);
    f_idx    = free_found ? free_idx : rd_idx;
    // A strict less-than keeps the lower index on a tie.
    take_min = (rd_idx == '0) | cmp_flag;
  end

  // The written record takes the next sequence number; it wraps freely.
  assign wr_en  = (state == ST_WRITE);
  assign wr_rec = '{tag: tag_q, hops: hops_q, snr_out: snr_out_q, snr_in: snr_in_q,
                    time_ms: time_q, order: order_counter + 32'd1};

  assign req.ready = (state == ST_IDLE);

  assign rsp.valid            = out_valid;
  assign rsp.hit              = out_res.hit;
  assign rsp.evicted          = out_res.evicted;
  assign rsp.slot             = out_res.slot;
  assign rsp.out_hop_num      = out_res.hops;
  assign rsp.out_snr_outbound = out_res.snr_out;
  assign rsp.out_snr_inbound  = out_res.snr_in;
  assign rsp.out_time_ms      = out_res.time_ms;
  assign rsp.out_order        = out_res.order;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      issue_on      <= 1'b0;
      pend          <= 1'b0;
      match_found   <= 1'b0;
      free_found    <= 1'b0;
      order_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      // The done state reloads the output register itself.
      if (out_valid && rsp.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      // Address issue, shared by both scan passes.
      if (state == ST_SCAN || state == ST_AGE) begin
        if (issue_on) begin
          pend   <= 1'b1;
          rd_idx <= cnt;
          if (cnt == LAST) begin
            issue_on <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end else begin
          pend <= 1'b0;
        end
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            req_type_q  <= req.req_type;
            tag_q       <= req.tag;
            hops_q      <= req.hop_num;
            snr_out_q   <= req.snr_outbound;
            snr_in_q    <= req.snr_inbound;
            time_q      <= req.now_ms;
            cnt         <= '0;
            issue_on    <= 1'b1;
            pend        <= 1'b0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            state       <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (pend) begin
            match_found <= m_found;
            match_idx   <= m_idx;
            match_rec   <= m_rec;
            free_found  <= f_found;
            free_idx    <= f_idx;
            if (rd_idx == LAST) begin
              res.hit     <= m_found;
              // Only a store into a full table evicts.
              res.evicted <= (req_type_q == REQ_STORE) & ~m_found & ~f_found;
              if (req_type_q == REQ_LOOKUP) begin
                // A miss reports all fields as zero.
                if (m_found) begin
                  res.slot    <= 4'(m_idx);
                  res.hops    <= m_rec.hops;
                  res.snr_out <= m_rec.snr_out;
                  res.snr_in  <= m_rec.snr_in;
                  res.time_ms <= m_rec.time_ms;
                  res.order   <= m_rec.order;
                end else begin
                  res.slot    <= '0;
                  res.hops    <= '0;
                  res.snr_out <= '0;
                  res.snr_in  <= '0;
                  res.time_ms <= '0;
                  res.order   <= '0;
                end
                state <= ST_DONE;
              end else if (m_found) begin
                tgt_idx <= m_idx;
                state   <= ST_WRITE;
              end else if (f_found) begin
                tgt_idx <= f_idx;
                state   <= ST_WRITE;
              end else begin
                // Table is full: second pass finds the oldest entry.
                cnt         <= '0;
                issue_on    <= 1'b1;
                state       <= ST_AGE;
              end
            end
          end
        end

        ST_AGE: begin
          if (pend) begin
            if (take_min) begin
              min_order <= rd_rec.order;
              min_idx   <= rd_idx;
            end
            if (rd_idx == LAST) begin
              tgt_idx <= take_min ? rd_idx : min_idx;
              state   <= ST_WRITE;
            end
          end
        end

        ST_WRITE: begin
          order_counter <= order_counter + 32'd1;
          res.slot      <= 4'(tgt_idx);
          res.hops      <= wr_rec.hops;
          res.snr_out   <= wr_rec.snr_out;
          res.snr_in    <= wr_rec.snr_in;
          res.time_ms   <= wr_rec.time_ms;
          res.order     <= wr_rec.order;
          state         <= ST_DONE;
        end

        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_res   <= res;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
